@@ hdl/indexed_list_engine_assert.svh @@
// assertion macros shared by the list engine modules
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ILE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/ile_pkg.sv @@
// shared types and defaults of the list engine
package ile_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int WIDTH_DEF = 32;

	typedef enum logic [3:0] {
		MODE_PUSH    = 4'd0,
		MODE_POP     = 4'd1,
		MODE_PEEK    = 4'd2,
		MODE_READ    = 4'd3,
		MODE_INSERT  = 4'd4,
		MODE_REMOVE  = 4'd5,
		MODE_REPLACE = 4'd6,
		MODE_SEARCH  = 4'd7,
		MODE_CLEAR   = 4'd8
	} mode_t;

	typedef enum logic [2:0] {
		ADDR_CNT,
		ADDR_CNT_M1,
		ADDR_POS,
		ADDR_IDX,
		ADDR_IDX_M1,
		ADDR_IDX_P1
	} addr_sel_t;

	typedef enum logic {
		WD_VAL,
		WD_RDATA
	} wd_sel_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_CNT,
		IDX_POS,
		IDX_ZERO,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_CLR
	} cnt_op_t;

	typedef struct packed {
		logic      req_load;
		logic      mem_rd;
		logic      mem_wr;
		addr_sel_t addr_sel;
		wd_sel_t   wd_sel;
		idx_op_t   idx_op;
		cnt_op_t   cnt_op;
		logic      set_ok;
		logic      cap_data;
		logic      cap_found;
		logic      res_load;
	} cmd_t;

	typedef struct packed {
		logic [3:0] mode;
		logic       full;
		logic       empty;
		logic       pos_lt_n;
		logic       pos_le_n;
		logic       idx_at_pos;
		logic       idx_at_cnt;
		logic       match;
	} sts_t;

endpackage

@@ hdl/ile_dp.sv @@
// list engine datapath: request, element memory, count, index and result registers
`include "indexed_list_engine_assert.svh"

module ile_dp #(
	parameter int DEPTH = ile_pkg::DEPTH_DEF,
	parameter int WIDTH = ile_pkg::WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  ile_pkg::cmd_t cmd,
	output ile_pkg::sts_t sts,
	input  logic [3:0]   mode,
	input  logic [6:0]   position,
	input  logic [31:0]  item_value,
	output logic         ok,
	output logic [31:0]  data_out,
	output logic [5:0]   found_position,
	output logic [6:0]   count_now
);
	import ile_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > 7) ? CW : 7;
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
	localparam logic [CW-1:0] ONE = CW'(1);

	logic [3:0]       mode_q;
	logic [6:0]       pos_q;
	logic [WIDTH-1:0] val_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    idx_q;
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;
	logic             ok_wq;
	logic [WIDTH-1:0] data_wq;
	logic [CW-1:0]    found_wq;
	logic [CW-1:0]    addr_full;
	logic [AW-1:0]    addr;
	logic [WIDTH-1:0] wr_data;

	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			mode_q <= mode;
			pos_q  <= position;
			val_q  <= WIDTH'(item_value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			unique case (cmd.cnt_op)
				CNT_HOLD: count_q <= count_q;
				CNT_INC:  count_q <= count_q + ONE;
				CNT_DEC:  count_q <= count_q - ONE;
				CNT_CLR:  count_q <= '0;
				default:  count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.idx_op)
			IDX_HOLD: idx_q <= idx_q;
			IDX_CNT:  idx_q <= count_q;
			IDX_POS:  idx_q <= CW'(pos_q);
			IDX_ZERO: idx_q <= '0;
			IDX_INC:  idx_q <= idx_q + ONE;
			IDX_DEC:  idx_q <= idx_q - ONE;
			default:  idx_q <= idx_q;
		endcase
	end

	always_comb begin
		unique case (cmd.addr_sel)
			ADDR_CNT:    addr_full = count_q;
			ADDR_CNT_M1: addr_full = count_q - ONE;
			ADDR_POS:    addr_full = CW'(pos_q);
			ADDR_IDX:    addr_full = idx_q;
			ADDR_IDX_M1: addr_full = idx_q - ONE;
			ADDR_IDX_P1: addr_full = idx_q + ONE;
			default:     addr_full = idx_q;
		endcase
	end

	assign addr    = addr_full[AW-1:0];
	assign wr_data = (cmd.wd_sel == WD_RDATA) ? rd_data_q : val_q;

	// single-port element memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem_q[addr] <= wr_data;
		end
		if (cmd.mem_rd) begin
			rd_data_q <= mem_q[addr];
		end
	end

	// working result, cleared per request so failures report zeros
	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			ok_wq    <= 1'b0;
			data_wq  <= '0;
			found_wq <= '0;
		end else begin
			if (cmd.set_ok) begin
				ok_wq <= 1'b1;
			end
			if (cmd.cap_data) begin
				data_wq <= rd_data_q;
			end
			if (cmd.cap_found) begin
				found_wq <= idx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			ok             <= ok_wq;
			data_out       <= 32'(data_wq);
			found_position <= 6'(found_wq);
			count_now      <= 7'(count_q);
		end
	end

	always_comb begin
		sts.mode       = mode_q;
		sts.full       = (count_q == CNT_FULL);
		sts.empty      = (count_q == '0);
		sts.pos_lt_n   = (PW'(pos_q) < PW'(count_q));
		sts.pos_le_n   = (PW'(pos_q) <= PW'(count_q));
		sts.idx_at_pos = (PW'(idx_q) == PW'(pos_q));
		sts.idx_at_cnt = (idx_q == count_q);
		sts.match      = (rd_data_q == val_q);
	end

	`ILE_ASSERT_NOW(a_count_range, 1'b1, count_q <= CNT_FULL, "count above capacity")
	`ILE_ASSERT_NOW(a_one_port, cmd.mem_wr, !cmd.mem_rd, "read and write in one cycle")
	`ILE_ASSERT_NOW(a_no_overfill, cmd.cnt_op == CNT_INC, !sts.full, "count grown past full")

endmodule

@@ hdl/ile_ctrl.sv @@
// list engine controller: request decode and the shift and search sequencer
`include "indexed_list_engine_assert.svh"

module ile_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  ile_pkg::sts_t sts,
	output ile_pkg::cmd_t cmd
);
	import ile_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_GRAB,
		S_INS_RD,
		S_INS_WR,
		S_REM_CAP,
		S_REM_RD,
		S_REM_WR,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.req_load  = 1'b0;
		cmd.mem_rd    = 1'b0;
		cmd.mem_wr    = 1'b0;
		cmd.addr_sel  = ADDR_IDX;
		cmd.wd_sel    = WD_VAL;
		cmd.idx_op    = IDX_HOLD;
		cmd.cnt_op    = CNT_HOLD;
		cmd.set_ok    = 1'b0;
		cmd.cap_data  = 1'b0;
		cmd.cap_found = 1'b0;
		cmd.res_load  = 1'b0;
		state_d       = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.req_load = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FINISH;
				unique case (sts.mode)
					MODE_PUSH: begin
						if (!sts.full) begin
							cmd.mem_wr   = 1'b1;
							cmd.addr_sel = ADDR_CNT;
							cmd.cnt_op   = CNT_INC;
							cmd.set_ok   = 1'b1;
						end
					end
					MODE_POP, MODE_PEEK: begin
						if (!sts.empty) begin
							cmd.mem_rd   = 1'b1;
							cmd.addr_sel = ADDR_CNT_M1;
							if (sts.mode == MODE_POP) begin
								cmd.cnt_op = CNT_DEC;
							end
							state_d = S_GRAB;
						end
					end
					MODE_READ: begin
						if (sts.pos_lt_n) begin
							cmd.mem_rd   = 1'b1;
							cmd.addr_sel = ADDR_POS;
							state_d      = S_GRAB;
						end
					end
					MODE_INSERT: begin
						if (sts.pos_le_n && !sts.full) begin
							cmd.idx_op = IDX_CNT;
							cmd.cnt_op = CNT_INC;
							state_d    = S_INS_RD;
						end
					end
					MODE_REMOVE: begin
						if (sts.pos_lt_n) begin
							cmd.mem_rd   = 1'b1;
							cmd.addr_sel = ADDR_POS;
							cmd.idx_op   = IDX_POS;
							cmd.cnt_op   = CNT_DEC;
							state_d      = S_REM_CAP;
						end
					end
					MODE_REPLACE: begin
						if (sts.pos_lt_n) begin
							cmd.mem_wr   = 1'b1;
							cmd.addr_sel = ADDR_POS;
							cmd.set_ok   = 1'b1;
						end
					end
					MODE_SEARCH: begin
						cmd.idx_op = IDX_ZERO;
						state_d    = S_SRCH_RD;
					end
					MODE_CLEAR: begin
						cmd.cnt_op = CNT_CLR;
						cmd.set_ok = 1'b1;
					end
					default: begin
						// unused codes fail with no change
						state_d = S_FINISH;
					end
				endcase
			end
			S_GRAB: begin
				cmd.cap_data = 1'b1;
				cmd.set_ok   = 1'b1;
				state_d      = S_FINISH;
			end
			S_INS_RD: begin
				// walk down from the old end, last step drops the new value in
				if (sts.idx_at_pos) begin
					cmd.mem_wr   = 1'b1;
					cmd.addr_sel = ADDR_POS;
					cmd.set_ok   = 1'b1;
					state_d      = S_FINISH;
				end else begin
					cmd.mem_rd   = 1'b1;
					cmd.addr_sel = ADDR_IDX_M1;
					state_d      = S_INS_WR;
				end
			end
			S_INS_WR: begin
				cmd.mem_wr   = 1'b1;
				cmd.addr_sel = ADDR_IDX;
				cmd.wd_sel   = WD_RDATA;
				cmd.idx_op   = IDX_DEC;
				state_d      = S_INS_RD;
			end
			S_REM_CAP: begin
				cmd.cap_data = 1'b1;
				state_d      = S_REM_RD;
			end
			S_REM_RD: begin
				// count already reduced, so the walk stops at the new end
				if (sts.idx_at_cnt) begin
					cmd.set_ok = 1'b1;
					state_d    = S_FINISH;
				end else begin
					cmd.mem_rd   = 1'b1;
					cmd.addr_sel = ADDR_IDX_P1;
					state_d      = S_REM_WR;
				end
			end
			S_REM_WR: begin
				cmd.mem_wr   = 1'b1;
				cmd.addr_sel = ADDR_IDX;
				cmd.wd_sel   = WD_RDATA;
				cmd.idx_op   = IDX_INC;
				state_d      = S_REM_RD;
			end
			S_SRCH_RD: begin
				if (sts.idx_at_cnt) begin
					state_d = S_FINISH;
				end else begin
					cmd.mem_rd   = 1'b1;
					cmd.addr_sel = ADDR_IDX;
					state_d      = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				if (sts.match) begin
					cmd.cap_found = 1'b1;
					cmd.set_ok    = 1'b1;
					state_d       = S_FINISH;
				end else begin
					cmd.idx_op = IDX_INC;
					state_d    = S_SRCH_RD;
				end
			end
			S_FINISH: begin
				// hold until the previous result beat has left
				if (!out_valid || out_ready) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	`ILE_ASSERT_NEXT(a_result_shown, cmd.res_load, out_valid, "loaded result not presented")
	`ILE_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second request taken early")
	`ILE_ASSERT_NEXT(a_hit_ends, (state_q == S_SRCH_CMP) && sts.match, state_q == S_FINISH,
		"search went on after a hit")

endmodule

@@ hdl/indexed_list_engine.sv @@
// indexed list engine top level: controller and datapath
//
//  beat     direction  handshake             payload
//  request  in         in_valid / in_ready   mode, position, item_value
//  result   out        out_valid / out_ready ok, data_out, found_position, count_now
//
// one request at a time; its result becomes valid in the same cycle in which the next
// request can be taken; the states a request passes through after acceptance:
//   decode, finish: push, replace, clear, failed or unused request
//   decode, grab, finish: pop, peek, read
//   insert, remove: a read and a write per element moved on the single memory port
//   search: a read and a compare per element until the hit or the end of the list
// a new request is taken while the previous result waits; arst_n empties the list
module indexed_list_engine #(
	parameter int DEPTH = ile_pkg::DEPTH_DEF,
	parameter int WIDTH = ile_pkg::WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  mode,
	input  logic [6:0]  position,
	input  logic [31:0] item_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [31:0] data_out,
	output logic [5:0]  found_position,
	output logic [6:0]  count_now
);
	import ile_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ile_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ile_dp #(
		.DEPTH (DEPTH),
		.WIDTH (WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.mode           (mode),
		.position       (position),
		.item_value     (item_value),
		.ok             (ok),
		.data_out       (data_out),
		.found_position (found_position),
		.count_now      (count_now)
	);

endmodule
